// ----- hdl/ohm_pkg.sv -----
// Shared types and constants for the offset histogram with mode search.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package ohm_pkg;

  localparam int BIN_COUNT     = 16384;
  localparam int COUNT_BITS    = 40;
  localparam int FRACTION_BITS = 8;

  localparam int IDX_W    = $clog2(BIN_COUNT);
  localparam int SAMPLE_W = 32;
  localparam int FIXED_W  = 40;
  localparam int FIELD_W  = 40;
  // Rounded magnitude needs FIXED_W + 1 - FRACTION_BITS bits, plus a sign.
  localparam int RMAG_W   = FIXED_W + 1 - FRACTION_BITS;
  localparam int VAL_W    = ((RMAG_W > SAMPLE_W) ? RMAG_W : SAMPLE_W + 1) + 1;
  localparam int DIFF_W   = VAL_W + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [FIXED_W:0] RND_HALF =
    (FRACTION_BITS > 0) ? (FIXED_W+1)'(1) << (FRACTION_BITS - 1) : '0;

  typedef enum logic [2:0] {
    OP_COUNT_INT = 3'd0,
    OP_COUNT_RND = 3'd1,
    OP_READ      = 3'd2,
    OP_CLEAR     = 3'd3,
    OP_MODE      = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_ROUND,
    ST_RANGE,
    ST_READ,
    ST_UPD,
    ST_SCAN,
    ST_SCAN_END,
    ST_MODE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic calc_val;
    logic calc_rng;
    logic cnt_clr;
    logic scan_init;
    logic clr_step;
    logic rd_bin;
    logic upd;
    logic scan_rd;
    logic mode_fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic oor;
    logic cnt_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/ohm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ohm_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hdl/ohm_ctrl.sv -----
// Controller state machine: sequences clear sweeps, count/read updates and mode scans.
// Depends on ohm_pkg; drives the datapath through cmd_t and reads sts_t.
`default_nettype none

module ohm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic          cfg_wr_en,
  input  wire ohm_pkg::sts_t sts,
  output ohm_pkg::cmd_t      cmd
);
  import ohm_pkg::*;

  state_t state_r, state_nxt;
  logic   clr_item_r, clr_item_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_item_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_item_r <= clr_item_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_item_nxt = clr_item_r;
    cmd          = '0;
    in_tready    = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.cnt_last) begin
          state_nxt    = clr_item_r ? ST_DONE : ST_IDLE;
          clr_item_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        in_tready = !cfg_wr_en;
        if (in_tvalid && !cfg_wr_en) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.calc_val = 1'b1;
        state_nxt    = ST_RANGE;
      end
      ST_RANGE: begin
        cmd.calc_rng = 1'b1;
        unique case (sts.op)
          OP_COUNT_INT, OP_COUNT_RND, OP_READ: begin
            state_nxt = sts.oor ? ST_DONE : ST_READ;
          end
          OP_CLEAR: begin
            cmd.cnt_clr  = 1'b1;
            clr_item_nxt = 1'b1;
            state_nxt    = ST_CLR;
          end
          OP_MODE: begin
            cmd.cnt_clr   = 1'b1;
            cmd.scan_init = 1'b1;
            state_nxt     = ST_SCAN;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_READ: begin
        cmd.rd_bin = 1'b1;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_nxt = ST_MODE;
      ST_MODE: begin
        cmd.mode_fin = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
    // An origin write restarts the clearing sweep.
    if (cfg_wr_en) begin
      cmd          = '0;
      cmd.cnt_clr  = 1'b1;
      in_tready    = 1'b0;
      clr_item_nxt = 1'b0;
      state_nxt    = ST_CLR;
    end
  end

  a_cfg_clears : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> state_r == ST_CLR)
    else $error("origin write did not start a clear sweep");

  a_upd_after_read : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |-> $past(state_r) == ST_READ)
    else $error("bin update without a preceding read");

  a_accept_idle : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_ROUND)
    else $error("accepted item did not enter evaluation");

endmodule

`default_nettype wire

// ----- hdl/ohm_dp.sv -----
// Datapath: input capture, rounding, range check, bin store, total, mode scan, output register.
// Depends on ohm_pkg and ohm_ram; commanded by ohm_ctrl.
`default_nettype none

module ohm_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ohm_pkg::cmd_t cmd,
  output ohm_pkg::sts_t      sts,
  input  wire logic [71:0]   in_tdata,
  input  wire logic [2:0]    in_tuser,
  input  wire logic          cfg_wr_en,
  input  wire logic [31:0]   cfg_wr_data,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [111:0]       out_tdata,
  output logic               out_tuser
);
  import ohm_pkg::*;

  op_t                      op_r;
  logic [SAMPLE_W-1:0]      sample_r;
  logic [FIXED_W-1:0]       fixed_r;
  logic [VAL_W-1:0]         val_r;
  logic [IDX_W-1:0]         idx_r;
  logic                     oor_r;
  logic [SAMPLE_W-1:0]      origin_r;
  logic [COUNT_BITS-1:0]    total_r;
  logic [IDX_W-1:0]         cnt_r;
  logic                     scan_vld_r;
  logic [IDX_W-1:0]         scan_idx_r;
  logic [COUNT_BITS-1:0]    best_r;
  logic [IDX_W-1:0]         at_r;
  logic [COUNT_BITS-1:0]    res_bin_r;
  logic [SAMPLE_W-1:0]      res_mode_r;
  logic                     res_status_r;
  logic                     out_vld_r;
  logic [FIELD_W-1:0]       out_bin_r;
  logic [SAMPLE_W-1:0]      out_mode_r;
  logic [FIELD_W-1:0]       out_total_r;
  logic                     out_status_r;

  logic                     neg;
  logic [FIXED_W:0]         fix_ext;
  logic [FIXED_W:0]         mag;
  logic [FIXED_W:0]         mag_rnd;
  logic [FIXED_W:0]         rnd;
  logic [VAL_W-1:0]         val_nxt;
  logic [DIFF_W-1:0]        lo;
  logic [DIFF_W-1:0]        diff;
  logic                     range_miss;
  logic                     is_count;
  logic [COUNT_BITS-1:0]    bin_rd;
  logic [COUNT_BITS-1:0]    bin_inc;
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0]    ram_wdata;
  logic [IDX_W-1:0]         ram_raddr;

  // Round half away from zero: add half an LSB to the magnitude, truncate, restore sign.
  assign neg     = fixed_r[FIXED_W-1];
  assign fix_ext = {fixed_r[FIXED_W-1], fixed_r};
  assign mag     = neg ? (FIXED_W+1)'(0) - fix_ext : fix_ext;
  assign mag_rnd = mag + RND_HALF;
  assign rnd     = mag_rnd >> FRACTION_BITS;

  always_comb begin
    if (op_r == OP_COUNT_RND) begin
      val_nxt = neg ? VAL_W'(0) - VAL_W'(rnd) : VAL_W'(rnd);
    end else begin
      val_nxt = {{(VAL_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};
    end
  end

  assign lo   = {{(DIFF_W-SAMPLE_W){origin_r[SAMPLE_W-1]}}, origin_r};
  assign diff = {val_r[VAL_W-1], val_r} - lo;
  assign range_miss = diff[DIFF_W-1] || (diff > DIFF_W'(BIN_COUNT - 1));

  assign is_count = (op_r == OP_COUNT_INT) || (op_r == OP_COUNT_RND);
  assign bin_inc  = (bin_rd == COUNT_MAX) ? bin_rd : bin_rd + COUNT_BITS'(1);

  assign ram_we    = cmd.clr_step || (cmd.upd && is_count);
  assign ram_waddr = cmd.clr_step ? cnt_r : idx_r;
  assign ram_wdata = cmd.clr_step ? '0 : bin_inc;
  assign ram_raddr = cmd.scan_rd ? cnt_r : idx_r;

  ohm_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BIN_COUNT)
  ) u_bins (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (bin_rd)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r   <= '0;
      total_r    <= '0;
      cnt_r      <= '0;
      scan_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        origin_r <= cfg_wr_data;
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.clr_step || cmd.scan_rd) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
      if (cmd.clr_step && sts.cnt_last) begin
        total_r <= '0;
      end else if (cmd.upd && is_count && total_r != COUNT_MAX) begin
        total_r <= total_r + COUNT_BITS'(1);
      end
      scan_vld_r <= cmd.scan_rd;
      if (cmd.out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op_t'(in_tuser);
      sample_r <= in_tdata[31:0];
      fixed_r  <= in_tdata[71:32];
    end
    if (cmd.calc_val) begin
      val_r <= val_nxt;
    end
    if (cmd.calc_rng) begin
      idx_r        <= diff[IDX_W-1:0];
      oor_r        <= range_miss;
      res_bin_r    <= '0;
      res_mode_r   <= '0;
      res_status_r <= (is_count || op_r == OP_READ) && range_miss;
    end
    scan_idx_r <= cnt_r;
    if (cmd.scan_init) begin
      best_r <= '0;
      at_r   <= '0;
    end else if (scan_vld_r && bin_rd > best_r) begin
      best_r <= bin_rd;
      at_r   <= scan_idx_r;
    end
    if (cmd.upd) begin
      res_bin_r <= is_count ? bin_inc : bin_rd;
    end
    if (cmd.mode_fin) begin
      res_bin_r  <= best_r;
      res_mode_r <= (best_r != '0) ?
                    origin_r + {{(SAMPLE_W-IDX_W){1'b0}}, at_r} : '0;
    end
    if (cmd.out_load) begin
      out_bin_r    <= FIELD_W'(res_bin_r);
      out_mode_r   <= res_mode_r;
      out_total_r  <= FIELD_W'(total_r);
      out_status_r <= res_status_r;
    end
  end

  // The range check is decided in the cycle it is computed.
  assign sts.op       = op_r;
  assign sts.oor      = range_miss;
  assign sts.cnt_last = (cnt_r == IDX_W'(BIN_COUNT - 1));
  assign sts.out_free = !out_vld_r || out_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_total_r, out_mode_r, out_bin_r};
  assign out_tuser  = out_status_r;

  a_scan_no_write : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_rd |-> !ram_we)
    else $error("bin write during mode scan");

  a_total_clear : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step && sts.cnt_last |=> total_r == '0)
    else $error("total not cleared at end of sweep");

  a_upd_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> !oor_r)
    else $error("bin update for an out-of-range value");

endmodule

`default_nettype wire

// ----- hdl/offset_histogram_with_mode_core.sv -----
// Top level of the offset histogram with mode search.
// Depends on ohm_pkg, ohm_ctrl, ohm_dp (which holds ohm_ram).
//
//  Channel  | Ports                                  | Contents (low bit first)
//  ---------+----------------------------------------+--------------------------------------
//  input    | in_tvalid/in_tready/in_tdata/in_tuser  | tdata: sample_value, rounded_sample
//           |                                        | tuser: opcode
//  result   | out_tvalid/out_tready/out_tdata/out_tuser | tdata: bin_count, mode_value,
//           |                                        | total_counted; tuser: status
//  config   | cfg_wr_en/cfg_wr_data                  | origin_value
//
// Sequence: an in-range count or read steps through capture, round, range check, RAM read,
// update and result load before the next item is taken; the single read port of the bin RAM
// and its registered read make the RAM read and the update separate steps. Out-of-range
// counts and reads and the unused opcodes skip the RAM. Clear and find mode sweep the bins,
// one bin per cycle through the RAM.
// Reset: rst_n is synchronous, active low. After reset, and after every origin write, a
// clearing pass zeroes the bins and the total; no item is taken then.
// Stalls: the result sits in an output register; the block goes back to idle and takes the
// next item while it waits, and holds the next result until the register is free.
`default_nettype none

module offset_histogram_with_mode_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [71:0]  in_tdata,   // [31:0] sample_value, [71:32] rounded_sample
  input  wire logic [2:0]   in_tuser,   // [2:0] opcode
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [111:0]      out_tdata,  // [39:0] bin_count, [71:40] mode_value,
                                        // [111:72] total_counted
  output logic              out_tuser,  // [0] status
  input  wire logic         cfg_wr_en,
  input  wire logic [31:0]  cfg_wr_data
);
  import ohm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence each item and the clearing sweeps.
  ohm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_wr_en (cfg_wr_en),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the origin, the bins, the total and the output register.
  ohm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // An out-of-range result never carries a bin count.
  a_oor_no_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[39:0] == '0)
    else $error("out-of-range result with nonzero bin count");

  // A reported mode always comes with a nonzero count.
  a_mode_has_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[71:40] != '0 |-> out_tdata[39:0] != '0)
    else $error("mode reported with empty bin");

  // No item is taken while a configuration write lands.
  a_cfg_no_accept : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |-> !in_tready)
    else $error("item accepted during origin write");

endmodule

`default_nettype wire
